FILE: hw/rtl/rsfp_pkg.sv
// range sensor frame parser package: item structs, verdict codes, frame bytes
// and register indexes shared by the top level and its checker
// no dependencies
`default_nettype none

package rsfp_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DISTANCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DISTANCE = 2'd1;

   localparam logic [15:0] MIN_DISTANCE_RESET = 16'd50;
   localparam logic [15:0] MAX_DISTANCE_RESET = 16'd4000;

   localparam logic [7:0] HDR_BYTE  = 8'h5A;
   localparam logic [7:0] TYPE_BYTE = 8'h15;
   localparam logic [7:0] LEN_BYTE  = 8'h03;
   localparam logic [3:0] NIBBLE    = 4'hF;

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_CHECKSUM = 2'd1,
      VERDICT_STATUS   = 2'd2,
      VERDICT_WINDOW   = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_error;
   } req_item_type;

   typedef struct packed {
      logic [15:0] distance_mm;
      logic [3:0]  range_status;
      verdict_type verdict;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/range_sensor_frame_parser_top.sv
// range sensor frame parser top level: byte-wise frame hunt, checksum and verdict
// depends on rsfp_pkg
//
// usage
//   req channel: one received byte and its line error flag per item, taken at an
//   edge with req_valid high and req_stall low
//   rsp channel: one item per completed 8-byte frame with distance, range status
//   and verdict, taken at an edge with rsp_valid high and rsp_stall low
//   csr channel: csr_ready is always high; index 0 min_distance, 1 max_distance,
//   other indexes ignored; write only while the block is idle
// latency: a byte taken at edge n is parsed at edge n+1, so the result of a
//   checksum byte shows on rsp_valid right after edge n+1
// throughput: one byte per cycle, set by the single registered parse stage
// reset: window returns to 50..4000, parser hunts for a header, both stages empty
// stall: a waiting result holds the rsp side; the parse stage keeps taking bytes
//   that cause no result and holds only a checksum byte until the result
//   register frees, which then backs up into req_stall
`default_nettype none

module range_sensor_frame_parser_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  rsfp_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output rsfp_pkg::rsp_item_type             rsp_item,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [rsfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [rsfp_pkg::CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [2:0] {
      POS_HUNT    = 3'd0,
      POS_HDR2    = 3'd1,
      POS_TYPE    = 3'd2,
      POS_LEN     = 3'd3,
      POS_DIST_HI = 3'd4,
      POS_DIST_LO = 3'd5,
      POS_STATUS  = 3'd6,
      POS_CSUM    = 3'd7
   } pos_type;

   logic                   s1_valid_ff, s1_valid_in;
   rsfp_pkg::req_item_type s1_item_ff;
   logic                   out_valid_ff, out_valid_in;
   rsfp_pkg::rsp_item_type out_item_ff, out_item_in;
   pos_type                pos_ff, pos_in;
   logic [7:0]             sum_ff, sum_in;
   logic [15:0]            dist_ff, dist_in;
   logic [3:0]             status_ff, status_in;
   logic [15:0]            min_ff, max_ff;

   logic                   gen;
   logic                   proc;
   logic                   take;
   logic [7:0]             b;
   rsfp_pkg::verdict_type  verdict;

   assign b    = s1_item_ff.rx_byte;
   assign gen  = s1_valid_ff && !s1_item_ff.line_error && (pos_ff == POS_CSUM);
   assign proc = s1_valid_ff && !(gen && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !proc;
   assign take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      priority if (sum_ff != b) begin
         verdict = rsfp_pkg::VERDICT_CHECKSUM;
      end else if (status_ff != 4'd0) begin
         verdict = rsfp_pkg::VERDICT_STATUS;
      end else if (dist_ff < min_ff || dist_ff > max_ff) begin
         verdict = rsfp_pkg::VERDICT_WINDOW;
      end else begin
         verdict = rsfp_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      dist_in   = dist_ff;
      status_in = status_ff;
      if (proc) begin
         if (s1_item_ff.line_error) begin
            pos_in = POS_HUNT;
            sum_in = 8'd0;
         end else begin
            unique case (pos_ff)
               POS_HUNT: begin
                  if (b == rsfp_pkg::HDR_BYTE) begin
                     pos_in = POS_HDR2;
                     sum_in = b;
                  end
               end
               POS_HDR2: begin
                  if (b == rsfp_pkg::HDR_BYTE) begin
                     pos_in = POS_TYPE;
                     sum_in = sum_ff + b;
                  end else begin
                     pos_in = POS_HUNT;
                     sum_in = 8'd0;
                  end
               end
               POS_TYPE, POS_LEN: begin
                  if ((pos_ff == POS_TYPE && b == rsfp_pkg::TYPE_BYTE) ||
                      (pos_ff == POS_LEN && b == rsfp_pkg::LEN_BYTE)) begin
                     pos_in = (pos_ff == POS_TYPE) ? POS_LEN : POS_DIST_HI;
                     sum_in = sum_ff + b;
                  end else if (b == rsfp_pkg::HDR_BYTE) begin
                     pos_in = POS_HDR2;
                     sum_in = rsfp_pkg::HDR_BYTE;
                  end else begin
                     pos_in = POS_HUNT;
                     sum_in = 8'd0;
                  end
               end
               POS_DIST_HI: begin
                  dist_in = {b, 8'd0};
                  sum_in  = sum_ff + b;
                  pos_in  = POS_DIST_LO;
               end
               POS_DIST_LO: begin
                  dist_in = {dist_ff[15:8], b};
                  sum_in  = sum_ff + b;
                  pos_in  = POS_STATUS;
               end
               POS_STATUS: begin
                  status_in = b[7:4] & rsfp_pkg::NIBBLE;
                  sum_in    = sum_ff + b;
                  pos_in    = POS_CSUM;
               end
               POS_CSUM: begin
                  pos_in = POS_HUNT;
                  sum_in = 8'd0;
               end
            endcase
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (proc && gen) begin
         out_valid_in             = 1'b1;
         out_item_in.distance_mm  = dist_ff;
         out_item_in.range_status = status_ff;
         out_item_in.verdict      = verdict;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_item_ff <= req_item;
      end
      out_item_ff <= out_item_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= POS_HUNT;
         sum_ff       <= 8'd0;
         dist_ff      <= 16'd0;
         status_ff    <= 4'd0;
         min_ff       <= rsfp_pkg::MIN_DISTANCE_RESET;
         max_ff       <= rsfp_pkg::MAX_DISTANCE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         dist_ff      <= dist_in;
         status_ff    <= status_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == rsfp_pkg::CSR_MIN_DISTANCE) begin
               min_ff <= csr_data;
            end
            if (csr_index == rsfp_pkg::CSR_MAX_DISTANCE) begin
               max_ff <= csr_data;
            end
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rsfp_checker.sv
// range sensor frame parser port checker and its bind to the top level
// depends on rsfp_pkg and range_sensor_frame_parser_top
`default_nettype none

module rsfp_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input rsfp_pkg::rsp_item_type  rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_ok_reliable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.verdict == rsfp_pkg::VERDICT_OK |->
      rsp_item.range_status == 4'd0)
      else $error("accepted frame with nonzero range status");

   a_status_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.verdict == rsfp_pkg::VERDICT_STATUS |->
      rsp_item.range_status != 4'd0)
      else $error("status verdict with zero range status");

endmodule

bind range_sensor_frame_parser_top rsfp_checker u_rsfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: bench/tb.sv
// testbench for range_sensor_frame_parser_top: directed byte script, then random frames,
// noise and broken sequences over several distance windows, checked by a frame predictor
// depends on rsfp_pkg and range_sensor_frame_parser_top
`timescale 1ns / 100ps

module tb;

   localparam logic [rsfp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [rsfp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam rsfp_pkg::rsp_item_type NO_FRAME = '0;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 230;

   typedef enum logic [2:0] {
      POS_HUNT, POS_HDR2, POS_TYPE, POS_LEN, POS_DIST_HI, POS_DIST_LO, POS_STATUS, POS_CHECK
   } frame_pos_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   typedef struct packed {
      logic [7:0]             rx_byte;
      logic                   line_error;
      logic                   typed;
      rsfp_pkg::rsp_item_type want;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   rsfp_pkg::req_item_type req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsfp_pkg::rsp_item_type rsp_item;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [rsfp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rsfp_pkg::CSR_DATA_W-1:0]  csr_data;

   frame_pos_type frame_pos;
   logic [7:0]    frame_sum;
   logic [15:0]   frame_dist;
   logic [3:0]    frame_status;
   logic [15:0]   win_min;
   logic [15:0]   win_max;

   rsfp_pkg::rsp_item_type pending_frames[$];
   script_row_type         opening_rows[36];
   int                     errors;
   int                     phase_items;
   int                     burst_left;
   bit                     sender_gaps;
   bit                     long_hold_req;
   stall_mode_type         stall_mode;

   range_sensor_frame_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      if (errors <= 40) $display("tb: mismatch at %0t: %s", $time, what);
   endtask

   task automatic parse_byte(input rsfp_pkg::req_item_type it, output bit done,
                             output rsfp_pkg::rsp_item_type res);
      logic [7:0] b;
      logic [7:0] want_byte;
      b = it.rx_byte;
      done = 1'b0;
      res = NO_FRAME;
      if (it.line_error) begin
         frame_pos = POS_HUNT;
         frame_sum = 8'h00;
      end else begin
         case (frame_pos)
            POS_HUNT: begin
               if (b == rsfp_pkg::HDR_BYTE) begin
                  frame_sum = b;
                  frame_pos = POS_HDR2;
               end
            end
            POS_HDR2: begin
               if (b == rsfp_pkg::HDR_BYTE) begin
                  frame_sum += b;
                  frame_pos = POS_TYPE;
               end else begin
                  frame_sum = 8'h00;
                  frame_pos = POS_HUNT;
               end
            end
            POS_TYPE, POS_LEN: begin
               want_byte = (frame_pos == POS_TYPE) ? rsfp_pkg::TYPE_BYTE : rsfp_pkg::LEN_BYTE;
               if (b == want_byte) begin
                  frame_sum += b;
                  frame_pos = (frame_pos == POS_TYPE) ? POS_LEN : POS_DIST_HI;
               end else if (b == rsfp_pkg::HDR_BYTE) begin
                  // mismatching header byte starts a new frame
                  frame_sum = rsfp_pkg::HDR_BYTE;
                  frame_pos = POS_HDR2;
               end else begin
                  frame_sum = 8'h00;
                  frame_pos = POS_HUNT;
               end
            end
            POS_DIST_HI: begin
               frame_dist = {b, 8'h00};
               frame_sum += b;
               frame_pos = POS_DIST_LO;
            end
            POS_DIST_LO: begin
               frame_dist[7:0] = b;
               frame_sum += b;
               frame_pos = POS_STATUS;
            end
            POS_STATUS: begin
               frame_status = b[7:4];
               frame_sum += b;
               frame_pos = POS_CHECK;
            end
            default: begin
               done = 1'b1;
               res.distance_mm = frame_dist;
               res.range_status = frame_status;
               if (frame_sum != b) res.verdict = rsfp_pkg::VERDICT_CHECKSUM;
               else if (frame_status != 4'h0) res.verdict = rsfp_pkg::VERDICT_STATUS;
               else if (frame_dist < win_min || frame_dist > win_max)
                  res.verdict = rsfp_pkg::VERDICT_WINDOW;
               else res.verdict = rsfp_pkg::VERDICT_OK;
               frame_sum = 8'h00;
               frame_pos = POS_HUNT;
            end
         endcase
      end
   endtask

   // called at a falling edge, returns at a falling edge with req_valid possibly still high
   task automatic send_byte(input logic [7:0] b, input logic err, input logic typed,
                            input rsfp_pkg::rsp_item_type typed_res);
      rsfp_pkg::req_item_type it;
      bit                     done;
      rsfp_pkg::rsp_item_type res;
      it.rx_byte = b;
      it.line_error = err;
      req_item = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(it, done, res);
      if (done) pending_frames.push_back(typed ? typed_res : res);
      phase_items++;
      @(negedge clock);
      if (sender_gaps) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic send_frame();
      logic [7:0] fb[8];
      logic [7:0] s;
      int kind;
      int cut;
      int err_at;
      int d;
      int k;
      kind = $urandom_range(0, 19);
      case ($urandom_range(0, 4))
         0: d = $urandom_range(0, 65535);
         1: d = int'(win_min) + $urandom_range(0, 4) - 2;
         2: d = int'(win_max) + $urandom_range(0, 4) - 2;
         3: d = $urandom_range(0, 255);
         default: d = (win_min <= win_max) ? $urandom_range(win_min, win_max)
                                            : $urandom_range(0, 65535);
      endcase
      fb[0] = rsfp_pkg::HDR_BYTE;
      fb[1] = rsfp_pkg::HDR_BYTE;
      fb[2] = rsfp_pkg::TYPE_BYTE;
      fb[3] = rsfp_pkg::LEN_BYTE;
      fb[4] = d[15:8];
      fb[5] = d[7:0];
      fb[6] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : {4'h0, 4'($urandom)};
      s = 8'h00;
      for (k = 0; k < 7; k++) s += fb[k];
      fb[7] = s;
      cut = 8;
      err_at = $urandom_range(0, 7);
      case (kind)
         14: fb[7] = s ^ 8'($urandom_range(1, 255));
         15: fb[2] = $urandom_range(0, 1) ? rsfp_pkg::HDR_BYTE : 8'($urandom);
         16: fb[3] = $urandom_range(0, 1) ? rsfp_pkg::HDR_BYTE : 8'($urandom);
         17: cut = $urandom_range(1, 7);
         19: begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, NO_FRAME);
            cut = 0;
         end
         default: ;
      endcase
      for (k = 0; k < cut; k++) begin
         if (kind == 18 && k == err_at) send_byte(8'($urandom), 1'b1, 1'b0, NO_FRAME);
         send_byte(fb[k], 1'b0, 1'b0, NO_FRAME);
      end
   endtask

   task automatic write_csr(input logic [rsfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rsfp_pkg::CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rsfp_pkg::CSR_MIN_DISTANCE: win_min = data;
         rsfp_pkg::CSR_MAX_DISTANCE: win_max = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall = 1'b1;
            repeat (100) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            case (stall_mode)
               STALL_RANDOM:  rsp_stall = ($urandom_range(0, 2) == 0);
               STALL_PATTERN: rsp_stall = ($urandom_range(0, 6) < 3) ^ rsp_stall;
               default:       rsp_stall = 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsfp_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            report($sformatf("unexpected item %h", rsp_item));
         end else begin
            want = pending_frames.pop_front();
            if (rsp_item.distance_mm !== want.distance_mm)
               report($sformatf("distance_mm %h, predicted %h",
                                rsp_item.distance_mm, want.distance_mm));
            if (rsp_item.range_status !== want.range_status)
               report($sformatf("range_status %h, predicted %h",
                                rsp_item.range_status, want.range_status));
            if (rsp_item.verdict !== want.verdict)
               report($sformatf("verdict %0d, predicted %0d", rsp_item.verdict, want.verdict));
         end
      end
   end

   initial begin
      int phase;
      int i;
      logic [15:0] w;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      phase_items = 0;
      burst_left = 3;
      sender_gaps = 1'b1;
      long_hold_req = 1'b0;
      stall_mode = STALL_NONE;
      frame_pos = POS_HUNT;
      frame_sum = 8'h00;
      frame_dist = 16'h0000;
      frame_status = 4'h0;
      win_min = rsfp_pkg::MIN_DISTANCE_RESET;
      win_max = rsfp_pkg::MAX_DISTANCE_RESET;
      opening_rows = '{
         // zero distance below the reset window
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'h5A, 1'b0, 1'b0, NO_FRAME},
         '{8'h15, 1'b0, 1'b0, NO_FRAME}, '{8'h03, 1'b0, 1'b0, NO_FRAME},
         '{8'h00, 1'b0, 1'b0, NO_FRAME}, '{8'h00, 1'b0, 1'b0, NO_FRAME},
         '{8'h00, 1'b0, 1'b0, NO_FRAME},
         '{8'hCC, 1'b0, 1'b1, '{16'h0000, 4'h0, rsfp_pkg::VERDICT_WINDOW}},
         // full distance, full status nibble
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'h5A, 1'b0, 1'b0, NO_FRAME},
         '{8'h15, 1'b0, 1'b0, NO_FRAME}, '{8'h03, 1'b0, 1'b0, NO_FRAME},
         '{8'hFF, 1'b0, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, 1'b0, NO_FRAME},
         '{8'hF0, 1'b0, 1'b0, NO_FRAME},
         '{8'hBA, 1'b0, 1'b1, '{16'hFFFF, 4'hF, rsfp_pkg::VERDICT_STATUS}},
         // line error, header byte in type slot, then frame at the window top
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'hFF, 1'b1, 1'b0, NO_FRAME},
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'h5A, 1'b0, 1'b0, NO_FRAME},
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'h5A, 1'b0, 1'b0, NO_FRAME},
         '{8'h15, 1'b0, 1'b0, NO_FRAME}, '{8'h03, 1'b0, 1'b0, NO_FRAME},
         '{8'h0F, 1'b0, 1'b0, NO_FRAME}, '{8'hA0, 1'b0, 1'b0, NO_FRAME},
         '{8'h00, 1'b0, 1'b0, NO_FRAME},
         '{8'h7B, 1'b0, 1'b1, '{16'd4000, 4'h0, rsfp_pkg::VERDICT_OK}},
         // bad checksum beats nonzero status
         '{8'h5A, 1'b0, 1'b0, NO_FRAME}, '{8'h5A, 1'b0, 1'b0, NO_FRAME},
         '{8'h15, 1'b0, 1'b0, NO_FRAME}, '{8'h03, 1'b0, 1'b0, NO_FRAME},
         '{8'h00, 1'b0, 1'b0, NO_FRAME}, '{8'h64, 1'b0, 1'b0, NO_FRAME},
         '{8'h30, 1'b0, 1'b0, NO_FRAME},
         '{8'h61, 1'b0, 1'b1, '{16'h0064, 4'h3, rsfp_pkg::VERDICT_CHECKSUM}}
      };
      repeat (4) @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < $size(opening_rows); i++)
         send_byte(opening_rows[i].rx_byte, opening_rows[i].line_error,
                   opening_rows[i].typed, opening_rows[i].want);
      settle();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         w = 16'($urandom);
         case (phase)
            1: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, 16'h0000);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, 16'hFFFF);
            end
            2: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, 16'hFFFF);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, 16'h0000);
            end
            3: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, w);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, w);
            end
            4: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, 16'h0000);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, 16'h0000);
            end
            5: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, rsfp_pkg::MIN_DISTANCE_RESET);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, rsfp_pkg::MAX_DISTANCE_RESET);
            end
            6: begin
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, w);
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, 16'($urandom_range(0, w)));
            end
            7: begin
               write_csr(rsfp_pkg::CSR_MIN_DISTANCE, 16'hFFFF);
               write_csr(rsfp_pkg::CSR_MAX_DISTANCE, 16'hFFFF);
            end
            default: ;
         endcase
         write_csr(phase[0] ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
         csr_valid = 1'b0;
         stall_mode = stall_mode_type'(phase % 3);
         sender_gaps = (phase != 2 && phase != 5);
         // receiver holds off while frames keep coming
         if (phase == 5) long_hold_req = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_frame();
         settle();
      end

      repeat (8) @(negedge clock);
      if (errors == 0 && pending_frames.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
